// ===== sv/ingress_packet_steering_unit_macros.svh =====
// Assertion macros shared by the steering unit RTL.
// Every macro expects clk and arst_n to be visible where it is used.
`ifndef INGRESS_PACKET_STEERING_UNIT_MACROS_SVH
`define INGRESS_PACKET_STEERING_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define IPS_ASSERT_NOW(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication.
`define IPS_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== sv/ips_pkg.sv =====
// Shared types and constants of the ingress packet steering unit.
// No dependencies; all files but the macro header import this package.
package ips_pkg;

	localparam int BYTE_W         = 8;
	localparam int QUEUE_W        = 8;
	localparam int COUNT_W        = 32;
	localparam int POS_W          = 7;
	localparam int LEN_W          = 8;
	localparam int MASK_W         = 64;
	localparam int MASK_IDX_W     = 6;
	localparam int PORT_W         = 16;
	localparam int ETYPE_W        = 16;
	localparam int IHL_W          = 4;
	localparam int APB_ADDR_W     = 4;
	localparam int APB_DATA_W     = 64;
	localparam int NUM_QUEUES_DEF = 64;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_W     = 2;
	localparam int FIFO_CNT_W     = 3;

	// Byte positions within the frame.
	localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
	localparam logic [POS_W-1:0] POS_IHL      = 7'd14;
	localparam logic [POS_W-1:0] POS_PROTO    = 7'd23;
	localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
	localparam logic [POS_W-1:0] ETH_HDR_POS  = 7'd14;

	// Frame length thresholds.
	localparam logic [LEN_W-1:0] LEN_MIN_ETH = 8'd14;
	localparam logic [LEN_W-1:0] LEN_MIN_IP  = 8'd34;
	localparam logic [LEN_W-1:0] TCP_MIN_LEN = 8'd20;

	localparam logic [ETYPE_W-1:0] ETYPE_ARP    = 16'h0806;
	localparam logic [ETYPE_W-1:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [BYTE_W-1:0]  IP_PROTO_TCP = 8'd6;
	localparam logic [PORT_W-1:0]  KEPT_PORT_RST = 16'd22;

	typedef enum logic {
		REG_BOUND_MASK = 1'b0,
		REG_KEPT_PORT  = 1'b1
	} reg_idx_t;

	// One classified frame handed from the parser to the counter stage.
	typedef struct packed {
		logic               early_pass;
		logic [QUEUE_W-1:0] queue;
	} job_t;

endpackage

// ===== sv/ips_if.sv =====
// Valid/ready channel interfaces of the steering unit: frame bytes in, verdicts out.
// Depends on ips_pkg for field widths.
interface ips_in_if;
	import ips_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  frame_byte;
	logic               last_byte;
	logic [QUEUE_W-1:0] queue_number;

	modport source (output valid, frame_byte, last_byte, queue_number, input ready);
	modport sink   (input valid, frame_byte, last_byte, queue_number, output ready);
endinterface

interface ips_out_if;
	import ips_pkg::*;

	logic               valid;
	logic               ready;
	logic               verdict;
	logic [QUEUE_W-1:0] queue_out;
	logic               was_counted;
	logic [COUNT_W-1:0] queue_count;

	modport source (output valid, verdict, queue_out, was_counted, queue_count, input ready);
	modport sink   (input valid, verdict, queue_out, was_counted, queue_count, output ready);
endinterface

// ===== sv/ingress_packet_steering_unit.sv =====
// Ingress packet steering unit. Frame bytes are accepted one per clock while the job
// queue has room, with no gaps required between frames; a verdict word leaves for every
// last byte, one per clock while the sink is ready, via the job queue, counter read and
// output registers. Per-queue counters live in a memory with one read and one write a
// cycle and a bypass for back-to-back frames of the same queue, so no counter access
// ever stalls the input. Counters read as zero after reset through per-queue valid bits;
// there is no clearing pass. Registers: bound queue mask at 0x0, kept TCP port at 0x8.
// Depends on ips_pkg, ips_if, ips_front, ips_fifo and ips_back.
module ingress_packet_steering_unit #(
	parameter int NUM_QUEUES = ips_pkg::NUM_QUEUES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ips_in_if.sink                         frames,
	ips_out_if.source                      verdicts,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ips_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ips_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ips_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import ips_pkg::*;

	logic [MASK_W-1:0] bound_mask_q;
	logic [PORT_W-1:0] kept_port_q;
	reg_idx_t          reg_idx;

	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t push_job;
	job_t pop_job;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_mask_q <= '0;
			kept_port_q  <= KEPT_PORT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BOUND_MASK: bound_mask_q <= pwdata;
				REG_KEPT_PORT:  kept_port_q  <= pwdata[PORT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BOUND_MASK: prdata = bound_mask_q;
			REG_KEPT_PORT:  prdata = {{(APB_DATA_W - PORT_W){1'b0}}, kept_port_q};
			default:        prdata = '0;
		endcase
	end

	ips_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frames    (frames),
		.kept_port (kept_port_q),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	ips_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	ips_back #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (pop_job),
		.empty      (empty),
		.pop        (pop),
		.bound_mask (bound_mask_q),
		.verdicts   (verdicts)
	);

endmodule

// ===== sv/ips_front.sv =====
// Frame parser: takes one byte per cycle while the job queue is not full, captures
// the header fields that matter and classifies the frame at its last byte. Depends on ips_pkg and ips_if.
module ips_front (
	input  logic                       clk,
	input  logic                       arst_n,
	ips_in_if.sink                     frames,
	input  logic [ips_pkg::PORT_W-1:0] kept_port,
	output logic                       push,
	output ips_pkg::job_t              push_job,
	input  logic                       full
);
	import ips_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic [ETYPE_W-1:0] etype_q;
	logic [IHL_W-1:0]   ihl_q;
	logic [BYTE_W-1:0]  proto_q;
	logic [PORT_W-1:0]  sport_q;
	logic [PORT_W-1:0]  dport_q;

	logic               accept;
	logic [BYTE_W-1:0]  b;
	logic [IHL_W-1:0]   ihl_cur;
	logic [POS_W-1:0]   tcp_off;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   tcp_end;
	logic [ETYPE_W-1:0] etype_now;
	logic               early;

	assign frames.ready = !full;
	assign accept       = frames.valid && frames.ready;
	assign b            = frames.frame_byte;

	// With IHL zero the TCP header starts at the IHL byte itself, so the offset
	// must already follow the byte being taken.
	assign ihl_cur = (pos_q == POS_IHL) ? b[IHL_W-1:0] : ihl_q;
	assign tcp_off = ETH_HDR_POS + {1'b0, ihl_cur, 2'b00};
	assign len     = {1'b0, pos_q} + LEN_W'(1);
	assign tcp_end = {1'b0, tcp_off} + TCP_MIN_LEN;

	// A 14-byte frame ends on the low EtherType byte.
	assign etype_now = {etype_q[15:8], (pos_q == POS_ETYPE_LO) ? b : etype_q[7:0]};

	always_comb begin
		early = 1'b0;
		if (len < LEN_MIN_ETH) begin
			early = 1'b1;
		end else if (etype_now == ETYPE_ARP) begin
			early = 1'b1;
		end else if (etype_now == ETYPE_IPV4) begin
			if (len < LEN_MIN_IP) begin
				early = 1'b1;
			end else if (proto_q == IP_PROTO_TCP) begin
				early = (len < tcp_end) || (sport_q == kept_port) || (dport_q == kept_port);
			end
		end
	end

	assign push                = accept && frames.last_byte;
	assign push_job.early_pass = early;
	assign push_job.queue      = frames.queue_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (frames.last_byte) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == POS_ETYPE_HI) etype_q[15:8] <= b;
			if (pos_q == POS_ETYPE_LO) etype_q[7:0] <= b;
			if (pos_q == POS_IHL) ihl_q <= b[IHL_W-1:0];
			if (pos_q == POS_PROTO) proto_q <= b;
			if (pos_q == tcp_off) sport_q[15:8] <= b;
			if (pos_q == tcp_off + POS_W'(1)) sport_q[7:0] <= b;
			if (pos_q == tcp_off + POS_W'(2)) dport_q[15:8] <= b;
			if (pos_q == tcp_off + POS_W'(3)) dport_q[7:0] <= b;
		end
	end

endmodule

// ===== sv/ips_fifo.sv =====
// Short job queue between the frame parser and the counter stage.
// Depends on ips_pkg for the job type and the queue depth.
module ips_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ips_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output ips_pkg::job_t pop_job,
	output logic          empty
);
	import ips_pkg::*;

	job_t                  slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== sv/ips_back.sv =====
// Counter stage: per-queue frame counters with read-modify-write and bypass,
// verdict lookup and the output register. Depends on ips_pkg, ips_if and the macros.
`include "ingress_packet_steering_unit_macros.svh"

module ips_back #(
	parameter int NUM_QUEUES = ips_pkg::NUM_QUEUES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ips_pkg::job_t              job,
	input  logic                       empty,
	output logic                       pop,
	input  logic [ips_pkg::MASK_W-1:0] bound_mask,
	ips_out_if.source                  verdicts
);
	import ips_pkg::*;

	localparam int QA_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [QUEUE_W:0] NQ = (QUEUE_W + 1)'(NUM_QUEUES);

	logic [COUNT_W-1:0] counters [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] live_q;

	logic               valid_s1;
	logic [QUEUE_W-1:0] queue_s1;
	logic               counts_s1;
	logic               fwd_s1;
	logic               live_s1;
	logic [COUNT_W-1:0] rd_s1;
	logic [COUNT_W-1:0] fwd_cnt_s1;

	logic               out_valid_q;
	logic               verdict_q;
	logic [QUEUE_W-1:0] queue_out_q;
	logic               was_counted_q;
	logic [COUNT_W-1:0] queue_count_q;

	logic               advance;
	logic [QA_W-1:0]    rd_addr;
	logic [QA_W-1:0]    wr_addr;
	logic               wr_en;
	logic [COUNT_W-1:0] old_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic               in_range;

	assign advance  = valid_s1 && (!out_valid_q || verdicts.ready);
	assign pop      = !empty && (!valid_s1 || advance);
	assign rd_addr  = job.queue[QA_W-1:0];
	assign wr_addr  = queue_s1[QA_W-1:0];
	assign wr_en    = advance && counts_s1;
	assign in_range = ({1'b0, job.queue} < NQ);

	// A write in the same edge as the read of that counter wins over the stale read.
	assign old_cnt = fwd_s1 ? fwd_cnt_s1 : (live_s1 ? rd_s1 : '0);
	assign new_cnt = old_cnt + COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (wr_en) counters[wr_addr] <= new_cnt;
		if (pop) begin
			rd_s1      <= counters[rd_addr];
			fwd_cnt_s1 <= new_cnt;
			queue_s1   <= job.queue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			valid_s1  <= 1'b0;
			counts_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
			live_s1   <= 1'b0;
		end else begin
			if (wr_en) live_q[wr_addr] <= 1'b1;
			if (pop) begin
				valid_s1  <= 1'b1;
				counts_s1 <= !job.early_pass && in_range;
				fwd_s1    <= wr_en && (wr_addr == rd_addr);
				live_s1   <= live_q[rd_addr];
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q     <= counts_s1 && bound_mask[queue_s1[MASK_IDX_W-1:0]];
			queue_out_q   <= queue_s1;
			was_counted_q <= counts_s1;
			queue_count_q <= counts_s1 ? new_cnt : '0;
		end
	end

	assign verdicts.valid       = out_valid_q;
	assign verdicts.verdict     = verdict_q;
	assign verdicts.queue_out   = queue_out_q;
	assign verdicts.was_counted = was_counted_q;
	assign verdicts.queue_count = queue_count_q;

	`IPS_ASSERT_NOW(a_redirect_counted, out_valid_q && verdict_q, was_counted_q, "redirect without count")
	`IPS_ASSERT_NOW(a_uncounted_zero, out_valid_q && !was_counted_q, queue_count_q == '0, "uncounted word has nonzero count")
	`IPS_ASSERT_NOW(a_counted_in_range, out_valid_q && was_counted_q, {1'b0, queue_out_q} < NQ, "counted queue out of range")
	`IPS_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(queue_s1), "stalled job lost")

endmodule
